/* hw/rtl/esitt_pkg.sv */
// Shared types, codes and constants of the ESI tag tokenizer.
package esitt_pkg;

  // Fixed limits of the tag grammar.
  localparam logic [5:0] COMMAND_MAX = 6'd32;
  localparam logic [5:0] KEY_MAX     = 6'd32;
  localparam logic [4:0] PARAMS_MAX  = 5'd16;
  localparam logic [2:0] INCLUDE_LEN = 3'd7;
  localparam logic [2:0] PREFIX_LEN  = 3'd4;

  // Configuration reset values.
  localparam logic [9:0] VALUE_LIMIT_RST = 10'd255;

  // Characters the parser looks for.
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_I      = 8'h69;

  // Parser states.
  typedef enum logic [4:0] {
    S_START, S_TAG, S_TAG_E, S_TAG_S, S_TAG_COLON, S_PRECMD, S_CMD,
    S_PREPARAM, S_PARAM, S_PREEQ, S_PREVAL, S_DQ, S_SQ, S_QSYM, S_POSTPARAM,
    S_TAGEND, S_ERR, S_ERREND
  } state_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_TEXT, KIND_CMD, KIND_KEY, KIND_VALUE, KIND_TAG_OK, KIND_TAG_ERR
  } kind_t;

  // Tag error reasons.
  typedef enum logic [2:0] {
    ERR_NONE, ERR_SYNTAX, ERR_CMD_LONG, ERR_KEY_LONG, ERR_VALUE_LONG,
    ERR_UNKNOWN_CMD, ERR_TOO_MANY_PARAMS, ERR_EMPTY_URI
  } err_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_VALUE_LIMIT = 1'b0,
    REG_ERR_MUTE    = 1'b1
  } reg_idx_t;

  // Results caused by one request: a replay of held prefix bytes,
  // followed by at most one final result.
  typedef struct packed {
    logic [2:0] rep_cnt;
    logic       fin_vld;
    kind_t      fin_kind;
    logic [7:0] fin_byte;
    logic [4:0] fin_idx;
    err_t       fin_err;
  } bundle_t;

  // Byte i of the held prefix "<esi".
  function automatic logic [7:0] prefix_char(input logic [1:0] i);
    logic [7:0] ch;
    case (i)
      2'd0:    ch = CH_LT;
      2'd1:    ch = CH_E;
      2'd2:    ch = CH_S;
      default: ch = CH_I;
    endcase
    return ch;
  endfunction

  // Byte i of the only accepted command, "include".
  function automatic logic [7:0] cmd_char(input logic [2:0] i);
    logic [7:0] ch;
    case (i)
      3'd0:    ch = 8'h69;
      3'd1:    ch = 8'h6E;
      3'd2:    ch = 8'h63;
      3'd3:    ch = 8'h6C;
      3'd4:    ch = 8'h75;
      3'd5:    ch = 8'h64;
      3'd6:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
  endfunction

endpackage

/* hw/rtl/esitt_ifs.sv */
// Valid/ready channel interfaces for the body bytes and the tokenizer results.
interface esitt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface esitt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic [4:0] param_index;
  logic [2:0] error_code;
  logic       last;

  modport source (
    output valid, output kind, output out_byte, output param_index,
    output error_code, output last, input ready
  );
  modport sink (
    input valid, input kind, input out_byte, input param_index,
    input error_code, input last, output ready
  );
endinterface

/* hw/rtl/esitt_parser.sv */
// Tag parser: parse state and counters, and the results of each accepted byte.
module esitt_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          data_byte,
  input  logic [9:0]          value_limit,
  input  logic                err_mute,
  output esitt_pkg::bundle_t  bundle
);
  import esitt_pkg::*;

  state_t      state_r, state_nxt;
  logic [2:0]  pm_r, pm_nxt;
  logic        erq_r, erq_nxt;
  logic [5:0]  cmd_len_r, cmd_len_nxt;
  logic        cmd_inc_r, cmd_inc_nxt;
  logic [5:0]  key_len_r, key_len_nxt;
  logic [9:0]  val_len_r, val_len_nxt;
  logic [4:0]  pcount_r, pcount_nxt;
  logic        fvn_r, fvn_nxt;
  err_t        err_r, err_nxt;

  logic [7:0]  want;
  state_t      want_next;
  logic [2:0]  rep_len;
  logic        store_ok;
  err_t        done_code;
  logic        ws;

  // State register, advanced once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_START;
      pm_r      <= '0;
      erq_r     <= 1'b0;
      cmd_len_r <= '0;
      cmd_inc_r <= 1'b1;
      key_len_r <= '0;
      val_len_r <= '0;
      pcount_r  <= '0;
      fvn_r     <= 1'b0;
      err_r     <= ERR_NONE;
    end else if (in_fire) begin
      state_r   <= state_nxt;
      pm_r      <= pm_nxt;
      erq_r     <= erq_nxt;
      cmd_len_r <= cmd_len_nxt;
      cmd_inc_r <= cmd_inc_nxt;
      key_len_r <= key_len_nxt;
      val_len_r <= val_len_nxt;
      pcount_r  <= pcount_nxt;
      fvn_r     <= fvn_nxt;
      err_r     <= err_nxt;
    end
  end

  // Helper terms shared by several states.
  always_comb begin
    ws       = is_ws(data_byte);
    rep_len  = (pm_r > PREFIX_LEN) ? PREFIX_LEN : pm_r;
    store_ok = val_len_r < value_limit;
    case (state_r)
      S_TAG: begin
        want      = CH_E;
        want_next = S_TAG_E;
      end
      S_TAG_E: begin
        want      = CH_S;
        want_next = S_TAG_S;
      end
      default: begin
        want      = CH_I;
        want_next = S_TAG_COLON;
      end
    endcase
    // Checks at the end of a well-formed tag, in priority order.
    if (!(cmd_inc_r && cmd_len_r == {3'b000, INCLUDE_LEN})) begin
      done_code = ERR_UNKNOWN_CMD;
    end else if (pcount_r > PARAMS_MAX) begin
      done_code = ERR_TOO_MANY_PARAMS;
    end else if (!fvn_r) begin
      done_code = ERR_EMPTY_URI;
    end else begin
      done_code = ERR_NONE;
    end
  end

  // Next state and results of the byte on the input.
  always_comb begin
    state_nxt   = state_r;
    pm_nxt      = pm_r;
    erq_nxt     = erq_r;
    cmd_len_nxt = cmd_len_r;
    cmd_inc_nxt = cmd_inc_r;
    key_len_nxt = key_len_r;
    val_len_nxt = val_len_r;
    pcount_nxt  = pcount_r;
    fvn_nxt     = fvn_r;
    err_nxt     = err_r;
    bundle      = '0;

    unique case (state_r) inside
      S_TAG, S_TAG_E, S_TAG_S, S_TAG_COLON: begin
        if (state_r != S_TAG_COLON && data_byte == want) begin
          pm_nxt    = pm_r + 3'd1;
          state_nxt = want_next;
        end else if (state_r == S_TAG_COLON && data_byte == CH_COLON) begin
          pm_nxt    = '0;
          err_nxt   = ERR_NONE;
          state_nxt = S_PRECMD;
        end else begin
          // Mismatch: replay the held prefix, then the byte unless it opens anew.
          bundle.rep_cnt = rep_len;
          if (data_byte == CH_LT) begin
            pm_nxt    = 3'd1;
            state_nxt = S_TAG;
          end else begin
            bundle.fin_vld  = 1'b1;
            bundle.fin_kind = KIND_TEXT;
            bundle.fin_byte = data_byte;
            pm_nxt          = '0;
            state_nxt       = S_START;
          end
        end
      end
      S_PRECMD: begin
        if (!ws) begin
          cmd_len_nxt     = 6'd1;
          cmd_inc_nxt     = data_byte == cmd_char(3'd0);
          pcount_nxt      = '0;
          fvn_nxt         = 1'b0;
          state_nxt       = S_CMD;
          bundle.fin_vld  = 1'b1;
          bundle.fin_kind = KIND_CMD;
          bundle.fin_byte = data_byte;
        end
      end
      S_CMD: begin
        if (ws) begin
          state_nxt = S_PREPARAM;
        end else if (data_byte == CH_SLASH) begin
          state_nxt = S_TAGEND;
        end else if (cmd_len_r >= COMMAND_MAX) begin
          err_nxt   = ERR_CMD_LONG;
          state_nxt = S_ERR;
        end else begin
          if (cmd_len_r >= {3'b000, INCLUDE_LEN} ||
              cmd_char(cmd_len_r[2:0]) != data_byte) begin
            cmd_inc_nxt = 1'b0;
          end
          cmd_len_nxt     = cmd_len_r + 6'd1;
          bundle.fin_vld  = 1'b1;
          bundle.fin_kind = KIND_CMD;
          bundle.fin_byte = data_byte;
        end
      end
      S_PREPARAM: begin
        if (ws) begin
          state_nxt = S_PREPARAM;
        end else if (data_byte == CH_SLASH) begin
          state_nxt = S_TAGEND;
        end else begin
          // A new key starts; the parameter count saturates one above the limit.
          if (pcount_r < PARAMS_MAX + 5'd1) begin
            pcount_nxt = pcount_r + 5'd1;
          end
          key_len_nxt     = 6'd1;
          val_len_nxt     = '0;
          state_nxt       = S_PARAM;
          bundle.fin_vld  = 1'b1;
          bundle.fin_kind = KIND_KEY;
          bundle.fin_byte = data_byte;
          bundle.fin_idx  = pcount_nxt;
        end
      end
      S_PARAM: begin
        if (ws) begin
          state_nxt = S_PREEQ;
        end else if (data_byte == CH_EQ) begin
          state_nxt = S_PREVAL;
        end else if (data_byte == CH_SLASH) begin
          err_nxt   = ERR_SYNTAX;
          state_nxt = S_ERREND;
        end else if (key_len_r >= KEY_MAX) begin
          err_nxt   = ERR_KEY_LONG;
          state_nxt = S_ERR;
        end else begin
          key_len_nxt     = key_len_r + 6'd1;
          bundle.fin_vld  = 1'b1;
          bundle.fin_kind = KIND_KEY;
          bundle.fin_byte = data_byte;
          bundle.fin_idx  = pcount_r;
        end
      end
      S_PREEQ: begin
        if (ws) begin
          state_nxt = S_PREEQ;
        end else if (data_byte == CH_EQ) begin
          state_nxt = S_PREVAL;
        end else begin
          err_nxt   = ERR_SYNTAX;
          state_nxt = (data_byte == CH_SLASH) ? S_ERREND : S_ERR;
        end
      end
      S_PREVAL: begin
        if (ws) begin
          state_nxt = S_PREVAL;
        end else if (data_byte == CH_DQUOTE) begin
          state_nxt = S_DQ;
        end else if (data_byte == CH_SQUOTE) begin
          state_nxt = S_SQ;
        end else begin
          err_nxt   = ERR_SYNTAX;
          state_nxt = (data_byte == CH_SLASH) ? S_ERREND : S_ERR;
        end
      end
      S_DQ, S_SQ, S_QSYM: begin
        if (state_r != S_QSYM &&
            data_byte == ((state_r == S_DQ) ? CH_DQUOTE : CH_SQUOTE)) begin
          state_nxt = S_POSTPARAM;
        end else begin
          if (state_r == S_QSYM) begin
            state_nxt = erq_r ? S_DQ : S_SQ;
          end else if (data_byte == CH_BSLASH) begin
            erq_nxt   = state_r == S_DQ;
            state_nxt = S_QSYM;
          end
          // Every stored value byte, escape included, needs room in the value.
          if (!store_ok) begin
            err_nxt   = ERR_VALUE_LONG;
            state_nxt = S_ERR;
          end else begin
            val_len_nxt = val_len_r + 10'd1;
            if (pcount_r == 5'd1) begin
              fvn_nxt = 1'b1;
            end
            bundle.fin_vld  = 1'b1;
            bundle.fin_kind = KIND_VALUE;
            bundle.fin_byte = data_byte;
            bundle.fin_idx  = pcount_r;
          end
        end
      end
      S_POSTPARAM: begin
        if (ws) begin
          state_nxt = S_PREPARAM;
        end else if (data_byte == CH_SLASH) begin
          state_nxt = S_TAGEND;
        end else begin
          err_nxt   = ERR_SYNTAX;
          state_nxt = S_ERR;
        end
      end
      S_TAGEND: begin
        if (data_byte == CH_GT) begin
          state_nxt = S_START;
          pm_nxt    = '0;
          if (done_code == ERR_NONE) begin
            bundle.fin_vld  = 1'b1;
            bundle.fin_kind = KIND_TAG_OK;
          end else if (!err_mute) begin
            bundle.fin_vld  = 1'b1;
            bundle.fin_kind = KIND_TAG_ERR;
            bundle.fin_err  = done_code;
          end
        end else begin
          err_nxt   = ERR_SYNTAX;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        if (data_byte == CH_SLASH) begin
          state_nxt = S_ERREND;
        end
      end
      S_ERREND: begin
        if (data_byte == CH_GT) begin
          state_nxt = S_START;
          pm_nxt    = '0;
          if (!err_mute) begin
            bundle.fin_vld  = 1'b1;
            bundle.fin_kind = KIND_TAG_ERR;
            bundle.fin_err  = (err_r != ERR_NONE) ? err_r : ERR_SYNTAX;
          end
        end else begin
          state_nxt = S_ERR;
        end
      end
      default: begin
        // Plain text; a '<' is held as the start of a possible tag.
        if (data_byte == CH_LT) begin
          pm_nxt    = 3'd1;
          state_nxt = S_TAG;
        end else begin
          pm_nxt          = '0;
          state_nxt       = S_START;
          bundle.fin_vld  = 1'b1;
          bundle.fin_kind = KIND_TEXT;
          bundle.fin_byte = data_byte;
        end
      end
    endcase
  end

endmodule

/* hw/rtl/esi_tag_tokenizer_core.sv */
// Top level of the ESI tag tokenizer: configuration registers and result register.
// The first result of a request is presented in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and the
// output is ready; a byte that yields several results holds the single result register
// until all have left (up to 5, on a replay of the held "<esi" prefix plus the mismatching byte).
// Reset: rst_n is synchronous and active low; it clears the parse state, configuration and result register.
module esi_tag_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  esitt_in_if.sink    in_ch,
  esitt_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import esitt_pkg::*;

  logic        in_fire;
  logic        out_fire;
  logic        out_done;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic [9:0]  value_limit_r;
  logic        silent_r;
  bundle_t     new_bundle;
  bundle_t     bun_r;
  logic        bun_valid_r;
  logic [2:0]  rep_pos_r;
  logic        cur_rep;
  logic        new_has_items;

  // Configuration port: never inserts wait states.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_limit_r <= VALUE_LIMIT_RST;
      silent_r      <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VALUE_LIMIT: value_limit_r <= pwdata[9:0];
        REG_ERR_MUTE:    silent_r      <= pwdata[0];
        default:         silent_r      <= silent_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_VALUE_LIMIT: prdata = {22'd0, value_limit_r};
      REG_ERR_MUTE:    prdata = {31'd0, silent_r};
      default:         prdata = '0;
    endcase
  end

  // Parser.
  esitt_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .data_byte   (in_ch.data_byte),
    .value_limit (value_limit_r),
    .err_mute    (silent_r),
    .bundle      (new_bundle)
  );

  // Current result: replayed prefix bytes first, then the final result.
  always_comb begin
    cur_rep = rep_pos_r < bun_r.rep_cnt;
    if (cur_rep) begin
      out_ch.kind        = KIND_TEXT;
      out_ch.out_byte    = prefix_char(rep_pos_r[1:0]);
      out_ch.param_index = '0;
      out_ch.error_code  = ERR_NONE;
      out_ch.last        = (rep_pos_r + 3'd1 == bun_r.rep_cnt) && !bun_r.fin_vld;
    end else begin
      out_ch.kind        = bun_r.fin_kind;
      out_ch.out_byte    = bun_r.fin_byte;
      out_ch.param_index = bun_r.fin_idx;
      out_ch.error_code  = bun_r.fin_err;
      out_ch.last        = 1'b1;
    end
  end

  // Handshakes: a new request is taken when no result is pending or as the last pending result leaves.
  assign out_ch.valid  = bun_valid_r;
  assign out_fire      = out_ch.valid && out_ch.ready;
  assign out_done      = out_fire && out_ch.last;
  assign in_ch.ready   = !bun_valid_r || out_done;
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign new_has_items = (new_bundle.rep_cnt != 3'd0) || new_bundle.fin_vld;

  // Result register and replay position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bun_valid_r <= 1'b0;
      rep_pos_r   <= '0;
    end else if (in_fire && new_has_items) begin
      bun_valid_r <= 1'b1;
      rep_pos_r   <= '0;
    end else if (out_done) begin
      bun_valid_r <= 1'b0;
    end else if (out_fire) begin
      rep_pos_r <= rep_pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && new_has_items) begin
      bun_r <= new_bundle;
    end
  end

  // Checks.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !bun_valid_r |-> in_ch.ready)
    else $error("input stalled with no pending result");

  a_drain_empties : assert property (@(posedge clk) disable iff (!rst_n)
    (out_done && !in_fire) |=> !out_ch.valid)
    else $error("result still valid after its last one left");

  a_replay_bound : assert property (@(posedge clk) disable iff (!rst_n)
    bun_valid_r |-> (rep_pos_r <= bun_r.rep_cnt && bun_r.rep_cnt <= PREFIX_LEN))
    else $error("replay position out of range");

  a_no_empty_result : assert property (@(posedge clk) disable iff (!rst_n)
    bun_valid_r |-> (rep_pos_r < bun_r.rep_cnt || bun_r.fin_vld))
    else $error("result register holds nothing to send");

  a_single_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_ch.last) |=> (out_ch.valid && $stable(bun_r)))
    else $error("request results broken off before the last one");

endmodule
